[rtl/lsft_pkg.sv]
// ----------------------------------------------------------------------------
// lsft_pkg
// Shared types and constants of the line sensor frame tracker.
// ----------------------------------------------------------------------------
package lsft_pkg;

  // fixed field widths
  localparam int CHAN_W     = 4;
  localparam int FUNC_W     = 2;
  localparam int FRAC_W     = 8;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 35;
  localparam int DIST_W     = 32;
  localparam int LOSS_W     = 31;
  localparam int STATE_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // queue between front and back, power of two
  localparam int QUEUE_DEPTH = 4;

  // item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE    = 2'd0,
    FUNC_CAL       = 2'd1,
    FUNC_TRK_RESET = 2'd2
  } func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_FRACTION = 2'd0,
    CFG_CROSS_COUNT     = 2'd1,
    CFG_LOSS_DISTANCE   = 2'd2
  } cfg_idx_e;

  // reported line state codes
  localparam logic [STATE_W-1:0] LS_NORMAL         = 3'd0;
  localparam logic [STATE_W-1:0] LS_NONE_DETECTING = 3'd1;
  localparam logic [STATE_W-1:0] LS_NONE           = 3'd2;
  localparam logic [STATE_W-1:0] LS_CROSS_PASSING  = 3'd3;
  localparam logic [STATE_W-1:0] LS_CROSS_PASSED   = 3'd4;

  // per-item control handed from front to back
  typedef struct packed {
    logic trk_reset;  // tracker reset item, no sample
    logic detect;     // sample above detect threshold
    logic last;       // last channel of the frame
    logic wneg;       // left side, weight is negative
  } ctl_t;

endpackage

[rtl/lsft_front.sv]
// ----------------------------------------------------------------------------
// lsft_front
// Accepts items, keeps the calibration tables, clamps and classifies samples
// and hands sample and tracker reset items to the queue.
// ----------------------------------------------------------------------------
module lsft_front #(
  parameter int NUM_SENSORS = 16,
  parameter int ADC_BITS    = 12,
  parameter int GAIN_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [lsft_pkg::FUNC_W-1:0]           func_i,
  input  logic [lsft_pkg::CHAN_W-1:0]           channel_i,
  input  logic [ADC_BITS-1:0]                   raw_sample_i,
  input  logic signed [lsft_pkg::DIST_W-1:0]    travelled_i,
  input  logic [ADC_BITS-1:0]                   cal_min_i,
  input  logic [ADC_BITS-1:0]                   cal_max_i,
  input  logic [GAIN_BITS-1:0]                  cal_gain_i,
  input  logic [lsft_pkg::FRAC_W-1:0]           detect_fraction_i,
  input  logic                                  fifo_full_i,
  output logic                                  push_o,
  output lsft_pkg::ctl_t                        ctl_o,
  output logic [ADC_BITS-1:0]                   diff_o,
  output logic [GAIN_BITS-1:0]                  gain_o,
  output logic [$clog2(NUM_SENSORS/2+1)-1:0]    wmag_o,
  output logic signed [lsft_pkg::DIST_W-1:0]    travelled_o
);
  import lsft_pkg::*;

  localparam int IDX_W  = $clog2(NUM_SENSORS);
  localparam int WIDE_W = CHAN_W + IDX_W;
  localparam int HALF   = NUM_SENSORS / 2;
  localparam int WMAG_W = $clog2(HALF + 1);
  localparam int THR_W  = ADC_BITS + FRAC_W;

  logic [ADC_BITS-1:0]  min_mem_q  [NUM_SENSORS];
  logic [ADC_BITS-1:0]  max_mem_q  [NUM_SENSORS];
  logic [GAIN_BITS-1:0] gain_mem_q [NUM_SENSORS];

  logic                 valid_q, valid_d;
  ctl_t                 ctl_q;
  logic [ADC_BITS-1:0]  diff_q;
  logic [GAIN_BITS-1:0] gain_q;
  logic [WMAG_W-1:0]    wmag_q;
  logic signed [DIST_W-1:0] trav_q;

  logic                 accept;
  logic [WIDE_W-1:0]    ch_wide;
  logic [IDX_W-1:0]     idx;
  logic                 ch_ok;
  logic                 is_sample, is_cal, is_reset, queued;
  logic [ADC_BITS-1:0]  lo, hi, v_hi, v;
  logic [THR_W-1:0]     thr;
  logic                 detect;
  logic [WMAG_W-1:0]    wmag;
  logic                 wneg;
  ctl_t                 ctl_n;

  // handshake
  assign push_o     = valid_q && !fifo_full_i;
  assign in_stall_o = valid_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // decode
  assign ch_wide   = WIDE_W'(channel_i);
  assign idx       = ch_wide[IDX_W-1:0];
  assign ch_ok     = ch_wide < WIDE_W'(NUM_SENSORS);
  assign is_sample = func_e'(func_i) == FUNC_SAMPLE;
  assign is_cal    = func_e'(func_i) == FUNC_CAL;
  assign is_reset  = func_e'(func_i) == FUNC_TRK_RESET;
  assign queued    = ch_ok && (is_sample || is_reset);

  // calibration tables
  always_ff @(posedge clk_i) begin
    if (accept && ch_ok && is_cal) begin
      min_mem_q[idx]  <= cal_min_i;
      max_mem_q[idx]  <= cal_max_i;
      gain_mem_q[idx] <= cal_gain_i;
    end
  end

  // clamp to max first, then raise to min
  always_comb begin
    lo   = min_mem_q[idx];
    hi   = max_mem_q[idx];
    v_hi = (raw_sample_i > hi) ? hi : raw_sample_i;
    v    = (v_hi < lo) ? lo : v_hi;
    thr  = THR_W'(hi) * THR_W'(detect_fraction_i);
    detect = {v, {FRAC_W{1'b0}}} > thr;
  end

  // position weight: right side positive, left side negative
  always_comb begin
    wmag = '0;
    wneg = 1'b0;
    if (ch_wide < WIDE_W'(HALF)) begin
      wmag = WMAG_W'(ch_wide + WIDE_W'(1));
    end else if (ch_wide < WIDE_W'(2 * HALF)) begin
      wmag = WMAG_W'(ch_wide - WIDE_W'(HALF) + WIDE_W'(1));
      wneg = 1'b1;
    end
  end

  always_comb begin
    ctl_n.trk_reset = is_reset;
    ctl_n.detect    = detect;
    ctl_n.last      = ch_wide == WIDE_W'(NUM_SENSORS - 1);
    ctl_n.wneg      = wneg;
  end

  // front register
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = queued;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q  <= ctl_n;
      diff_q <= v - lo;
      gain_q <= gain_mem_q[idx];
      wmag_q <= wmag;
      trav_q <= travelled_i;
    end
  end

  assign ctl_o       = ctl_q;
  assign diff_o      = diff_q;
  assign gain_o      = gain_q;
  assign wmag_o      = wmag_q;
  assign travelled_o = trav_q;

endmodule

[rtl/lsft_fifo.sv]
// ----------------------------------------------------------------------------
// lsft_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module lsft_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  import lsft_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/lsft_back.sv]
// ----------------------------------------------------------------------------
// lsft_back
// Scales and weights samples, accumulates the frame and runs the line
// tracker at the last channel; holds the result register.
// ----------------------------------------------------------------------------
module lsft_back #(
  parameter int NUM_SENSORS = 16,
  parameter int ADC_BITS    = 12,
  parameter int GAIN_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  output logic                                  pop_o,
  input  logic                                  empty_i,
  input  lsft_pkg::ctl_t                        ctl_i,
  input  logic [ADC_BITS-1:0]                   diff_i,
  input  logic [GAIN_BITS-1:0]                  gain_i,
  input  logic [$clog2(NUM_SENSORS/2+1)-1:0]    wmag_i,
  input  logic signed [lsft_pkg::DIST_W-1:0]    travelled_i,
  input  logic [lsft_pkg::CNT_W-1:0]            cross_count_i,
  input  logic [lsft_pkg::LOSS_W-1:0]           loss_distance_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic [lsft_pkg::STATE_W-1:0]          line_state_o,
  output logic [lsft_pkg::CNT_W-1:0]            detect_total_o,
  output logic signed [lsft_pkg::SUM_W-1:0]     error_sum_o,
  output logic                                  error_valid_o
);
  import lsft_pkg::*;

  localparam int WMAG_W  = $clog2(NUM_SENSORS/2 + 1);
  localparam int PROD1_W = GAIN_BITS + ADC_BITS;
  localparam int PROD_W  = PROD1_W + WMAG_W;
  localparam int ACC_W   = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 2;
  localparam int DD_W    = DIST_W + 2;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'({1'b0, {(SUM_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [4:0] {
    TRK_NORMAL         = 5'b00001,
    TRK_NONE_DETECTING = 5'b00010,
    TRK_NONE           = 5'b00100,
    TRK_CROSS_PASSING  = 5'b01000,
    TRK_CROSS_PASSED   = 5'b10000
  } trk_state_e;

  logic adv;

  // stage 1: gain product
  logic                     s1_valid_q;
  ctl_t                     s1_ctl_q;
  logic [PROD1_W-1:0]       s1_scaled_q;
  logic [WMAG_W-1:0]        s1_wmag_q;
  logic signed [DIST_W-1:0] s1_trav_q;

  // stage 2: weight product
  logic                     s2_valid_q;
  ctl_t                     s2_ctl_q;
  logic [PROD_W-1:0]        s2_prod_q;
  logic signed [DIST_W-1:0] s2_trav_q;

  // frame and tracker state
  logic [CNT_W-1:0]         count_q, cnt_n;
  logic signed [SUM_W-1:0]  sum_q, sum_n;
  trk_state_e               state_q, state_n;
  logic signed [DIST_W-1:0] loss_start_q, ls_n;
  logic                     err_valid_n;
  logic [STATE_W-1:0]       ls_code;

  logic signed [ACC_W-1:0]  acc, addend;
  logic signed [DD_W-1:0]   dd;
  logic [DD_W-1:0]          dd_abs;
  logic                     far;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic                     emit;
  logic [STATE_W-1:0]       line_state_q;
  logic [CNT_W-1:0]         detect_total_q;
  logic signed [SUM_W-1:0]  error_sum_q;
  logic                     error_valid_q;

  // the whole back pipeline moves when the result slot is free or taken
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q    <= ctl_i;
      s1_scaled_q <= {{ADC_BITS{1'b0}}, gain_i} * {{GAIN_BITS{1'b0}}, diff_i};
      s1_wmag_q   <= wmag_i;
      s1_trav_q   <= travelled_i;
      s2_ctl_q    <= s1_ctl_q;
      s2_prod_q   <= {{WMAG_W{1'b0}}, s1_scaled_q} * {{PROD1_W{1'b0}}, s1_wmag_q};
      s2_trav_q   <= s1_trav_q;
    end
  end

  // saturating count and sum
  always_comb begin
    cnt_n  = (s2_ctl_q.detect && count_q != '1) ? count_q + CNT_W'(1) : count_q;
    addend = signed'(ACC_W'(s2_prod_q));
    acc    = s2_ctl_q.wneg ? ACC_W'(sum_q) - addend : ACC_W'(sum_q) + addend;
    if (acc > SAT_HI) begin
      sum_n = SAT_HI[SUM_W-1:0];
    end else if (acc < SAT_LO) begin
      sum_n = SAT_LO[SUM_W-1:0];
    end else begin
      sum_n = acc[SUM_W-1:0];
    end
  end

  // distance since the line was lost
  always_comb begin
    dd     = DD_W'(s2_trav_q) - DD_W'(loss_start_q);
    dd_abs = (dd < 0) ? DD_W'(-dd) : DD_W'(dd);
    far    = dd_abs >= DD_W'(loss_distance_i);
  end

  // tracker update at the end of a frame
  always_comb begin
    state_n     = state_q;
    ls_n        = loss_start_q;
    err_valid_n = 1'b0;
    if (cnt_n == '0) begin
      if (state_q == TRK_NONE_DETECTING) begin
        if (far) begin
          state_n = TRK_NONE;
        end
      end else if (state_q != TRK_NONE) begin
        state_n = TRK_NONE_DETECTING;
        ls_n    = s2_trav_q;
      end
    end else if (cnt_n >= cross_count_i) begin
      state_n = TRK_CROSS_PASSING;
    end else begin
      state_n     = (state_q == TRK_CROSS_PASSING) ? TRK_CROSS_PASSED : TRK_NORMAL;
      err_valid_n = 1'b1;
    end
  end

  always_comb begin
    unique case (state_n)
      TRK_NORMAL:         ls_code = LS_NORMAL;
      TRK_NONE_DETECTING: ls_code = LS_NONE_DETECTING;
      TRK_NONE:           ls_code = LS_NONE;
      TRK_CROSS_PASSING:  ls_code = LS_CROSS_PASSING;
      TRK_CROSS_PASSED:   ls_code = LS_CROSS_PASSED;
      default:            ls_code = LS_NORMAL;
    endcase
  end

  // frame accumulators and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      sum_q        <= '0;
      state_q      <= TRK_NORMAL;
      loss_start_q <= '0;
    end else if (adv && s2_valid_q) begin
      if (s2_ctl_q.trk_reset) begin
        state_q <= TRK_NORMAL;
      end else if (s2_ctl_q.last) begin
        count_q      <= '0;
        sum_q        <= '0;
        state_q      <= state_n;
        loss_start_q <= ls_n;
      end else begin
        count_q <= cnt_n;
        sum_q   <= sum_n;
      end
    end
  end

  // result register
  assign emit = adv && s2_valid_q && !s2_ctl_q.trk_reset && s2_ctl_q.last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      line_state_q   <= ls_code;
      detect_total_q <= cnt_n;
      error_sum_q    <= sum_n;
      error_valid_q  <= err_valid_n;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_state_o   = line_state_q;
  assign detect_total_o = detect_total_q;
  assign error_sum_o    = error_sum_q;
  assign error_valid_o  = error_valid_q;

endmodule

[rtl/line_sensor_frame_tracker.sv]
// ----------------------------------------------------------------------------
// line_sensor_frame_tracker
// Per-sample clamp, detect and weighted sum over a frame of line sensors,
// with a five-state line tracker updated at the last channel.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless stalled; the back multiplies run in
//   gain and weight product stages. A last-channel item passes the front
//   register, queue, two multiply stages and result register, in order.
// A stalled result holds the back pipe; the 4-entry queue and front register
//   keep taking items until they fill.
// Reset: async, active low; clears tracker, frame sums and handshake state.
//   Calibration tables are not cleared and must be written before use.
module line_sensor_frame_tracker #(
  parameter int NUM_SENSORS = 16,
  parameter int ADC_BITS    = 12,
  parameter int GAIN_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [lsft_pkg::FUNC_W-1:0]           func_i,
  input  logic [lsft_pkg::CHAN_W-1:0]           channel_i,
  input  logic [ADC_BITS-1:0]                   raw_sample_i,
  input  logic signed [lsft_pkg::DIST_W-1:0]    travelled_i,
  input  logic [ADC_BITS-1:0]                   cal_min_i,
  input  logic [ADC_BITS-1:0]                   cal_max_i,
  input  logic [GAIN_BITS-1:0]                  cal_gain_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [lsft_pkg::STATE_W-1:0]          line_state_o,
  output logic [lsft_pkg::CNT_W-1:0]            detect_total_o,
  output logic signed [lsft_pkg::SUM_W-1:0]     error_sum_o,
  output logic                                  error_valid_o,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lsft_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lsft_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import lsft_pkg::*;

  localparam int WMAG_W = $clog2(NUM_SENSORS/2 + 1);
  localparam int CTL_W  = $bits(ctl_t);
  localparam int Q_W    = CTL_W + DIST_W + WMAG_W + GAIN_BITS + ADC_BITS;

  logic [FRAC_W-1:0] detect_fraction_q;
  logic [CNT_W-1:0]  cross_count_q;
  logic [LOSS_W-1:0] loss_distance_q;

  logic                     push, full, pop, empty;
  ctl_t                     fr_ctl, hd_ctl;
  logic [ADC_BITS-1:0]      fr_diff, hd_diff;
  logic [GAIN_BITS-1:0]     fr_gain, hd_gain;
  logic [WMAG_W-1:0]        fr_wmag, hd_wmag;
  logic signed [DIST_W-1:0] fr_trav, hd_trav;
  logic [Q_W-1:0]           q_wr, q_rd;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_fraction_q <= FRAC_W'(128);
      cross_count_q     <= CNT_W'(8);
      loss_distance_q   <= LOSS_W'(1000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DETECT_FRACTION: detect_fraction_q <= cfg_data_i[FRAC_W-1:0];
        CFG_CROSS_COUNT:     cross_count_q     <= cfg_data_i[CNT_W-1:0];
        CFG_LOSS_DISTANCE:   loss_distance_q   <= cfg_data_i[LOSS_W-1:0];
        default: ;
      endcase
    end
  end

  lsft_front #(
    .NUM_SENSORS (NUM_SENSORS),
    .ADC_BITS    (ADC_BITS),
    .GAIN_BITS   (GAIN_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .channel_i         (channel_i),
    .raw_sample_i      (raw_sample_i),
    .travelled_i       (travelled_i),
    .cal_min_i         (cal_min_i),
    .cal_max_i         (cal_max_i),
    .cal_gain_i        (cal_gain_i),
    .detect_fraction_i (detect_fraction_q),
    .fifo_full_i       (full),
    .push_o            (push),
    .ctl_o             (fr_ctl),
    .diff_o            (fr_diff),
    .gain_o            (fr_gain),
    .wmag_o            (fr_wmag),
    .travelled_o       (fr_trav)
  );

  // queue entry packing
  assign q_wr = {fr_ctl, fr_trav, fr_wmag, fr_gain, fr_diff};
  assign {hd_ctl, hd_trav, hd_wmag, hd_gain, hd_diff} = q_rd;

  lsft_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wr),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_rd)
  );

  lsft_back #(
    .NUM_SENSORS (NUM_SENSORS),
    .ADC_BITS    (ADC_BITS),
    .GAIN_BITS   (GAIN_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_o           (pop),
    .empty_i         (empty),
    .ctl_i           (hd_ctl),
    .diff_i          (hd_diff),
    .gain_i          (hd_gain),
    .wmag_i          (hd_wmag),
    .travelled_i     (hd_trav),
    .cross_count_i   (cross_count_q),
    .loss_distance_i (loss_distance_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .line_state_o    (line_state_o),
    .detect_total_o  (detect_total_o),
    .error_sum_o     (error_sum_o),
    .error_valid_o   (error_valid_o)
  );

endmodule

[rtl/lsft_checker.sv]
// ----------------------------------------------------------------------------
// lsft_checker
// Port-level checks on the result channel of the line sensor frame tracker.
// ----------------------------------------------------------------------------
module lsft_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [lsft_pkg::STATE_W-1:0]      line_state_o,
  input logic [lsft_pkg::CNT_W-1:0]        detect_total_o,
  input logic signed [lsft_pkg::SUM_W-1:0] error_sum_o,
  input logic                              error_valid_o
);
  import lsft_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_state_o) &&
      $stable(detect_total_o) && $stable(error_sum_o) && $stable(error_valid_o))
    else $error("stalled result changed");

  // no result while held in reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // a usable error only comes from the normal branch
  a_err_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_valid_o |->
      (line_state_o == LS_NORMAL || line_state_o == LS_CROSS_PASSED) &&
      detect_total_o != '0)
    else $error("error valid outside normal branch");

  // an empty frame means the line is being lost or is lost
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && detect_total_o == '0 |->
      !error_valid_o &&
      (line_state_o == LS_NONE_DETECTING || line_state_o == LS_NONE))
    else $error("empty frame with wrong line state");

endmodule

bind line_sensor_frame_tracker lsft_checker u_lsft_checker (.*);
